// ===== src/sogs_pkg.sv =====
// sogs_pkg: widths, register indexes, reset values and small helpers for the
// octagonal gate shaper. No dependencies; used by sogs_div_lane and the core.
`default_nettype none

package sogs_pkg;

  // field widths
  localparam int SAMPLE_W = 16;   // signed sample, Q1.x
  localparam int REACH_W  = 7;    // reach registers
  localparam int OUT_W    = 8;    // signed drive value
  localparam int QW       = 7;    // drive magnitude, 0..127

  // datapath widths
  localparam int PX_W  = SAMPLE_W + REACH_W + 1;  // signed reach * sample
  localparam int MAG_W = PX_W - 1;                // |reach * sample|
  localparam int LIM_W = 2 * REACH_W;             // axis * diagonal
  localparam int GB_W  = MAG_W + REACH_W;         // diagonal * larger magnitude
  localparam int WS_W  = 32;                      // signed weight * smaller magnitude
  localparam int D_W   = 29;                      // gate measure, never negative
  localparam int NUM_W = MAG_W + LIM_W;           // |x| * lim
  localparam int DEN_W = 32;                      // 5 * gate measure
  localparam int OUT_MUL_SH = 4;                  // the 16 of 16/5
  localparam int REM_W = NUM_W + OUT_MUL_SH;      // divider remainder

  // divider: one saturation check, then one quotient bit per stage
  localparam int DIV_STAGES  = QW + 1;
  localparam int PIPE_STAGES = DIV_STAGES + 5;
  localparam int ST_DIV0     = 4;

  // plain divide by five of a small value: (t * 205) >> 10, exact below 1024
  localparam int DIV5_MUL   = 205;
  localparam int DIV5_SHIFT = 10;
  localparam int DIV5_PW    = DIV5_SHIFT + 8;
  localparam int SAT_IN     = 640;                // 5 * 128

  localparam logic [QW-1:0] Q_SAT = '1;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_REACH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DIAG_REACH = 1'b1;

  localparam logic [REACH_W-1:0] AXIS_RESET = 7'd72;
  localparam logic [REACH_W-1:0] DIAG_RESET = 7'd40;

  typedef struct packed {
    logic          neg_x;
    logic          neg_y;
    logic          scale;
    logic [QW-1:0] ux;
    logic [QW-1:0] uy;
  } side_t;

  function automatic logic [OUT_W-1:0] apply_sign(input logic neg, input logic [QW-1:0] q);
    logic [OUT_W-1:0] m;
    m = {1'b0, q};
    return neg ? (~m + 8'd1) : m;
  endfunction

endpackage

`default_nettype wire

// ===== src/sogs_div_lane.sv =====
// sogs_div_lane: pipelined restoring divider for one axis, saturating quotient.
// Depends on sogs_pkg; stage enables come from the core's handshake chain.
`default_nettype none

module sogs_div_lane (
  input  logic                           clk_i,
  input  logic [sogs_pkg::DIV_STAGES-1:0] en_i,
  input  logic [sogs_pkg::NUM_W-1:0]      num_i,
  input  logic [sogs_pkg::DEN_W-1:0]      den_i,
  output logic [sogs_pkg::QW-1:0]         quo_o
);
  import sogs_pkg::*;

  logic [REM_W-1:0]      rem_q [DIV_STAGES-1];
  logic [DEN_W-1:0]      den_q [DIV_STAGES-1];
  logic [QW-1:0]         quo_q [DIV_STAGES];
  logic [DIV_STAGES-1:0] sat_q;

  logic [REM_W-1:0]      sub   [DIV_STAGES-1];
  logic [DIV_STAGES-2:0] ge;

  // trial subtract of the shifted divisor, one quotient bit per stage
  always_comb begin
    for (int i = 0; i < DIV_STAGES - 1; i++) begin
      sub[i] = REM_W'(den_q[i]) << (DIV_STAGES - 2 - i);
      ge[i]  = rem_q[i] >= sub[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0] <= REM_W'(num_i) << OUT_MUL_SH;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      // quotient of 128 or more saturates
      sat_q[0] <= (REM_W'(num_i) << OUT_MUL_SH) >= (REM_W'(den_i) << QW);
    end
    for (int i = 0; i < DIV_STAGES - 1; i++) begin
      if (en_i[i+1]) begin
        quo_q[i+1] <= quo_q[i] | (QW'(ge[i]) << (DIV_STAGES - 2 - i));
        sat_q[i+1] <= sat_q[i];
      end
    end
    for (int i = 0; i < DIV_STAGES - 2; i++) begin
      if (en_i[i+1]) begin
        rem_q[i+1] <= ge[i] ? (rem_q[i] - sub[i]) : rem_q[i];
        den_q[i+1] <= den_q[i];
      end
    end
  end

  assign quo_o = sat_q[DIV_STAGES-1] ? Q_SAT : quo_q[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== src/stick_octagon_gate_shaper_core.sv =====
// stick_octagon_gate_shaper_core: pipelined from input acceptance to a valid result.
// throughput one transaction per cycle while the output is not stalled; the pipeline holds the
// eight-stage restoring divider (one saturation check and seven quotient bits, one per stage).
// reset: axis_reach 72, diagonal_reach 40, pipeline empty; no clearing pass.
// depends on sogs_pkg and sogs_div_lane.
`default_nettype none

module stick_octagon_gate_shaper_core #(
  parameter int FRAC_BITS = 15
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write port
  input  logic                                  cfg_we_i,
  input  logic [sogs_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [sogs_pkg::REACH_W-1:0]          cfg_data_i,
  // sample channel
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [sogs_pkg::SAMPLE_W-1:0]  pos_x_i,
  input  logic signed [sogs_pkg::SAMPLE_W-1:0]  pos_y_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [sogs_pkg::OUT_W-1:0]     drive_x_o,
  output logic signed [sogs_pkg::OUT_W-1:0]     drive_y_o
);
  import sogs_pkg::*;

  // unscaled path: trunc(16 |x| / (5 * 2^FRAC_BITS)) = (|x| >> (FRAC_BITS-4)) / 5
  localparam int SH     = FRAC_BITS - OUT_MUL_SH;
  localparam int TW     = MAG_W - SH;
  localparam int UW     = (TW > DIV5_SHIFT) ? TW : DIV5_SHIFT;
  // threshold lim * 2^FRAC_BITS against the gate measure
  localparam int THR_W  = LIM_W + FRAC_BITS;
  localparam int CMP_W  = (THR_W > D_W) ? THR_W : D_W;
  localparam int ST_OUT = PIPE_STAGES - 1;

  function automatic logic [QW-1:0] div5_sat(input logic [MAG_W-1:0] mag);
    logic [UW-1:0]      t;
    logic [DIV5_PW-1:0] p;
    t = UW'(TW'(mag >> SH));
    p = DIV5_PW'(t[DIV5_SHIFT-1:0]) * DIV5_PW'(DIV5_MUL);
    return (t >= UW'(SAT_IN)) ? Q_SAT : p[DIV5_SHIFT +: QW];
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers; lim_q follows them in the next cycle, which is
  // covered because it is first read in the second stage
  // ---------------------------------------------------------------------------
  logic [REACH_W-1:0] axis_q, diag_q;
  logic [LIM_W-1:0]   lim_q, lim_d;

  assign lim_d = LIM_W'(axis_q) * LIM_W'(diag_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= AXIS_RESET;
      diag_q <= DIAG_RESET;
      lim_q  <= LIM_W'(AXIS_RESET) * LIM_W'(DIAG_RESET);
    end else begin
      lim_q <= lim_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_AXIS_REACH: axis_q <= cfg_data_i;
          REG_DIAG_REACH: diag_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage valids and advance chain: a stage takes a new transaction when it is
  // empty or its content moves on, so bubbles close up behind a stalled output
  // ---------------------------------------------------------------------------
  logic [PIPE_STAGES-1:0] v_q;
  logic [PIPE_STAGES-1:0] adv;

  always_comb begin
    adv[ST_OUT] = !v_q[ST_OUT] || out_ready_i;
    for (int k = ST_OUT - 1; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o = adv[0];

  // ---------------------------------------------------------------------------
  // stage 0: scale by axis reach, split into sign and magnitude
  // ---------------------------------------------------------------------------
  logic signed [PX_W-1:0] px, py;
  logic [MAG_W-1:0]       s0_mag_x_q, s0_mag_y_q;
  logic                   s0_neg_x_q, s0_neg_y_q;

  assign px = $signed({1'b0, axis_q}) * pos_x_i;
  assign py = $signed({1'b0, axis_q}) * pos_y_i;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s0_neg_x_q <= px[PX_W-1];
      s0_neg_y_q <= py[PX_W-1];
      s0_mag_x_q <= px[PX_W-1] ? MAG_W'(-px) : MAG_W'(px);
      s0_mag_y_q <= py[PX_W-1] ? MAG_W'(-py) : MAG_W'(py);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: gate measure products, scaled numerators, unscaled results
  // ---------------------------------------------------------------------------
  logic                   x_major;
  logic [MAG_W-1:0]       mag_hi, mag_lo;
  logic signed [REACH_W:0] wgt;
  logic [GB_W-1:0]        s1_gb_q;
  logic signed [WS_W-1:0] s1_ws_q;
  logic [NUM_W-1:0]       s1_num_x_q, s1_num_y_q;
  side_t                  s1_side_q, s1_side_d;

  assign x_major = s0_mag_y_q <= s0_mag_x_q;
  assign mag_hi  = x_major ? s0_mag_x_q : s0_mag_y_q;
  assign mag_lo  = x_major ? s0_mag_y_q : s0_mag_x_q;
  // weight on the smaller magnitude, negative when diagonal exceeds axis reach
  assign wgt     = $signed({1'b0, axis_q}) - $signed({1'b0, diag_q});

  always_comb begin
    s1_side_d       = '0;
    s1_side_d.neg_x = s0_neg_x_q;
    s1_side_d.neg_y = s0_neg_y_q;
    s1_side_d.ux    = div5_sat(s0_mag_x_q);
    s1_side_d.uy    = div5_sat(s0_mag_y_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s1_gb_q    <= GB_W'(diag_q) * GB_W'(mag_hi);
      s1_ws_q    <= WS_W'(wgt) * $signed({{(WS_W - MAG_W){1'b0}}, mag_lo});
      s1_num_x_q <= NUM_W'(lim_q) * NUM_W'(s0_mag_x_q);
      s1_num_y_q <= NUM_W'(lim_q) * NUM_W'(s0_mag_y_q);
      s1_side_q  <= s1_side_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: gate measure sum
  // ---------------------------------------------------------------------------
  logic signed [WS_W-1:0] d_sum;
  logic [D_W-1:0]         s2_d_q;
  logic [NUM_W-1:0]       s2_num_x_q, s2_num_y_q;
  side_t                  s2_side_q;

  assign d_sum = $signed({{(WS_W - GB_W){1'b0}}, s1_gb_q}) + s1_ws_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s2_d_q     <= d_sum[D_W-1:0];
      s2_num_x_q <= s1_num_x_q;
      s2_num_y_q <= s1_num_y_q;
      s2_side_q  <= s1_side_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: threshold compare and divisor 5 * d
  // ---------------------------------------------------------------------------
  logic [CMP_W-1:0] thr;
  logic [DEN_W-1:0] s3_den_q;
  logic [NUM_W-1:0] s3_num_x_q, s3_num_y_q;
  side_t            s3_side_q, s3_side_d;

  assign thr = CMP_W'(lim_q) << FRAC_BITS;

  always_comb begin
    s3_side_d       = s2_side_q;
    s3_side_d.scale = thr < CMP_W'(s2_d_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      s3_den_q   <= (DEN_W'(s2_d_q) << 2) + DEN_W'(s2_d_q);
      s3_num_x_q <= s2_num_x_q;
      s3_num_y_q <= s2_num_y_q;
      s3_side_q  <= s3_side_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stages 4 to 11: one divider lane per axis, sideband travels alongside
  // ---------------------------------------------------------------------------
  logic [QW-1:0] quo_x, quo_y;
  side_t         side_q [DIV_STAGES];

  sogs_div_lane u_div_x (
    .clk_i (clk_i),
    .en_i  (adv[ST_DIV0 +: DIV_STAGES]),
    .num_i (s3_num_x_q),
    .den_i (s3_den_q),
    .quo_o (quo_x)
  );

  sogs_div_lane u_div_y (
    .clk_i (clk_i),
    .en_i  (adv[ST_DIV0 +: DIV_STAGES]),
    .num_i (s3_num_y_q),
    .den_i (s3_den_q),
    .quo_o (quo_y)
  );

  always_ff @(posedge clk_i) begin
    if (adv[ST_DIV0]) begin
      side_q[0] <= s3_side_q;
    end
    for (int k = 1; k < DIV_STAGES; k++) begin
      if (adv[ST_DIV0 + k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 12: output register, pick scaled or unscaled magnitude, restore sign
  // ---------------------------------------------------------------------------
  side_t         side_last;
  logic [QW-1:0] mag_x_sel, mag_y_sel;
  logic [OUT_W-1:0] drive_x_q, drive_y_q;

  assign side_last = side_q[DIV_STAGES-1];
  assign mag_x_sel = side_last.scale ? quo_x : side_last.ux;
  assign mag_y_sel = side_last.scale ? quo_y : side_last.uy;

  always_ff @(posedge clk_i) begin
    if (adv[ST_OUT]) begin
      drive_x_q <= apply_sign(side_last.neg_x, mag_x_sel);
      drive_y_q <= apply_sign(side_last.neg_y, mag_y_sel);
    end
  end

  assign out_valid_o = v_q[ST_OUT];
  assign drive_x_o   = $signed(drive_x_q);
  assign drive_y_o   = $signed(drive_y_q);

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // input back-pressure only when every stage is occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&v_q))
    else $error("input stalled with a free stage");

  // an empty output stage never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output stage empty");

  // saturation keeps results inside +-127
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (drive_x_o != -8'sd128) && (drive_y_o != -8'sd128))
    else $error("drive value out of range");

endmodule

`default_nettype wire
